// ----- hw/rtl/spi_midi_frame_bridge_macros.svh -----
// Assertion macros for the checker of the SPI MIDI frame bridge.
// No dependencies; included by the checker file.
`ifndef SPI_MIDI_FRAME_BRIDGE_MACROS_SVH
`define SPI_MIDI_FRAME_BRIDGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/spi_mfb_pkg.sv -----
// Shared types and constants of the SPI MIDI frame bridge.
// No dependencies; imported by the credit unit, the top level and the checker.
`timescale 1ns / 1ps

package spi_mfb_pkg;

    localparam int BYTE_W     = 8;
    localparam int CREDIT_W   = 20;
    localparam int COST_W     = 16;
    localparam int THR_W      = 13;
    localparam int TICK_W     = 16;
    localparam int PROD_W     = TICK_W + CREDIT_W;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // The frame fields carry at most two slots.
    localparam int MAX_IO_SLOTS = 2;
    localparam int SLOT_W       = 1;

    localparam logic [BYTE_W-1:0] TAG_LED   = 8'hf0;
    localparam logic [BYTE_W-1:0] TAG_MIDI  = 8'h0f;
    localparam logic [BYTE_W-1:0] TAG_EMPTY = 8'h00;

    localparam logic [OP_W-1:0] OP_QUEUE = 3'd0;
    localparam logic [OP_W-1:0] OP_LED   = 3'd1;
    localparam logic [OP_W-1:0] OP_BUILD = 3'd2;
    localparam logic [OP_W-1:0] OP_RECV  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY   = 3'd3;

    localparam logic [CREDIT_W-1:0] CAPACITY_RESET = 20'd127000;
    localparam logic [COST_W-1:0]   COST_RESET     = 16'd1000;
    localparam logic [CREDIT_W-1:0] DRAIN_RESET    = 20'd12500;
    localparam logic [THR_W-1:0]    NOTIFY_RESET   = 13'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLOT,
        ST_SLOT_RD,
        ST_DRAIN,
        ST_PUSH,
        ST_POP_RD,
        ST_FINISH
    } state_t;

    // Commands from the sequencer to the credit unit.
    typedef struct packed {
        logic load_product;
        logic drain;
        logic charge;
    } credit_ctl_t;

endpackage

// ----- hw/rtl/spi_mfb_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; used for both byte FIFOs of the bridge.
`timescale 1ns / 1ps

module spi_mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/spi_mfb_credit.sv -----
// Remote buffer credit estimate: send test, per-byte charge and per-frame drain.
// Depends on spi_mfb_pkg.
`timescale 1ns / 1ps

module spi_mfb_credit
    import spi_mfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  credit_ctl_t         ctl,
    input  logic [TICK_W-1:0]   ticks,
    input  logic [CREDIT_W-1:0] drain_rate,
    input  logic [COST_W-1:0]   cost,
    input  logic [CREDIT_W-1:0] capacity,
    output logic [CREDIT_W-1:0] used,
    output logic                send_ok
);

    logic [CREDIT_W-1:0] used_credit_reg;
    logic [CREDIT_W-1:0] used_credit_next;
    logic [PROD_W-1:0]   product_reg;
    logic [CREDIT_W:0]   charged;

    // One extra bit so the sum of credit and cost cannot wrap.
    assign charged = {1'b0, used_credit_reg} + {{(CREDIT_W + 1 - COST_W){1'b0}}, cost};
    assign send_ok = charged < {1'b0, capacity};

    always_comb
    begin
        used_credit_next = used_credit_reg;
        if (ctl.charge)
        begin
            used_credit_next = charged[CREDIT_W] ? '1 : charged[CREDIT_W-1:0];
        end
        else if (ctl.drain)
        begin
            if (product_reg >= {{TICK_W{1'b0}}, used_credit_reg})
            begin
                used_credit_next = '0;
            end
            else
            begin
                used_credit_next = used_credit_reg - product_reg[CREDIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_credit_reg <= '0;
        end
        else
        begin
            used_credit_reg <= used_credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_product)
        begin
            product_reg <= ticks * drain_rate;
        end
    end

    assign used = used_credit_reg;

endmodule

// ----- hw/rtl/spi_midi_frame_bridge.sv -----
// Host side of a full-duplex SPI frame link. Queue, LED and unused ops finish in EXEC, a
// pop loads its byte in POP_RD, a received frame drains credit in DRAIN and pushes its
// slots in PUSH, and a build walks SLOT and SLOT_RD. A new item is taken only in IDLE,
// once the last one has gone to the output register. The FIFO memory reads and the drain
// multiply are registered. Reset clears pointers, credit, LED state and the output valid
// flag and restores the configuration defaults at once; the FIFO memories are not cleared.
`timescale 1ns / 1ps

module spi_midi_frame_bridge
    import spi_mfb_pkg::*;
#(
    parameter int FIFO_DEPTH      = 4096,
    parameter int SLOTS_PER_FRAME = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [OP_W-1:0]                   op,
    input  logic [BYTE_W-1:0]                 data_byte,
    input  logic [BYTE_W-1:0]                 rx_tag0,
    input  logic [BYTE_W-1:0]                 rx_data0,
    input  logic [BYTE_W-1:0]                 rx_tag1,
    input  logic [BYTE_W-1:0]                 rx_data1,
    input  logic [TICK_W-1:0]                 elapsed_ticks,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic [BYTE_W-1:0]                 tx_tag0,
    output logic [BYTE_W-1:0]                 tx_data0,
    output logic [BYTE_W-1:0]                 tx_tag1,
    output logic [BYTE_W-1:0]                 tx_data1,
    output logic [BYTE_W-1:0]                 rx_byte,
    output logic                              rx_valid,
    output logic                              notify,
    output logic                              more_work,
    output logic [$clog2(FIFO_DEPTH):0]       input_count,
    output logic [CREDIT_W-1:0]               credit_used,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data
);

    // FIFO_DEPTH is a power of two. Pointers carry one bit more than the address so that
    // a full FIFO and an empty one differ; the fill count is then a plain difference.
    localparam int ADDR_W   = $clog2(FIFO_DEPTH);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int CNT_W    = PTR_W;
    localparam int CMP_W    = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int IO_SLOTS = (SLOTS_PER_FRAME < MAX_IO_SLOTS) ? SLOTS_PER_FRAME
                                                                : MAX_IO_SLOTS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(IO_SLOTS - 1);

    // Sequencer state.
    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // Configuration registers.
    logic [CREDIT_W-1:0] capacity_reg;
    logic [COST_W-1:0]   cost_reg;
    logic [CREDIT_W-1:0] drain_reg;
    logic [THR_W-1:0]    threshold_reg;

    // FIFO pointers and LED state.
    logic [PTR_W-1:0]  out_head_reg, out_head_next;
    logic [PTR_W-1:0]  out_tail_reg, out_tail_next;
    logic [PTR_W-1:0]  in_head_reg, in_head_next;
    logic [PTR_W-1:0]  in_tail_reg, in_tail_next;
    logic              led_pending_reg, led_pending_next;
    logic [BYTE_W-1:0] led_dur_reg, led_dur_next;
    logic              last_data_reg, last_data_next;

    // The accepted item, held while it is worked on.
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] rtag_reg [MAX_IO_SLOTS];
    logic [BYTE_W-1:0] rdat_reg [MAX_IO_SLOTS];
    logic [TICK_W-1:0] ticks_reg;

    // Result under construction.
    logic              acc_reg;
    logic              any_reg;
    logic [BYTE_W-1:0] tag_reg  [MAX_IO_SLOTS];
    logic [BYTE_W-1:0] tdat_reg [MAX_IO_SLOTS];
    logic [BYTE_W-1:0] rxb_reg;
    logic              rxv_reg;

    // Output register: holds a finished result beat until it is taken.
    logic              out_valid_reg, out_valid_next;
    logic              o_acc_reg;
    logic [BYTE_W-1:0] o_tag_reg  [MAX_IO_SLOTS];
    logic [BYTE_W-1:0] o_tdat_reg [MAX_IO_SLOTS];
    logic [BYTE_W-1:0] o_rxb_reg;
    logic              o_rxv_reg;
    logic              o_notify_reg;
    logic              o_more_reg;
    logic [CNT_W-1:0]  o_count_reg;
    logic [CREDIT_W-1:0] o_credit_reg;

    // Strobes from the sequencer to the datapath registers.
    logic work_clr, acc_set, acc_clr, any_set, slot_led, slot_midi, rx_load, load_out;
    logic out_we, out_re, in_we, in_re;

    logic [BYTE_W-1:0]   out_rdata, in_rdata;
    logic [PTR_W-1:0]    out_count, in_count;
    logic                out_full, in_full;
    logic [CREDIT_W-1:0] credit;
    logic                send_ok;
    credit_ctl_t         cctl;
    logic                notify_now, more_now;

    assign out_count = out_tail_reg - out_head_reg;
    assign in_count  = in_tail_reg - in_head_reg;
    assign out_full  = out_count[PTR_W-1];
    assign in_full   = in_count[PTR_W-1];

    assign notify_now = CMP_W'(in_count) > CMP_W'(threshold_reg);
    assign more_now   = (out_count != '0) || led_pending_reg || (credit != '0) ||
                        last_data_reg;

    // Outgoing MIDI bytes: written at the tail on a queue op, read at the head while a
    // frame is built.
    spi_mfb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(FIFO_DEPTH)
    ) u_out_ram (
        .clk  (clk),
        .we   (out_we),
        .waddr(out_tail_reg[ADDR_W-1:0]),
        .wdata(data_reg),
        .re   (out_re),
        .raddr(out_head_reg[ADDR_W-1:0]),
        .rdata(out_rdata)
    );

    // Received bytes: one slot is written per cycle, and pops read at the head.
    spi_mfb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(FIFO_DEPTH)
    ) u_in_ram (
        .clk  (clk),
        .we   (in_we),
        .waddr(in_tail_reg[ADDR_W-1:0]),
        .wdata(rdat_reg[slot_reg]),
        .re   (in_re),
        .raddr(in_head_reg[ADDR_W-1:0]),
        .rdata(in_rdata)
    );

    spi_mfb_credit u_credit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cctl),
        .ticks     (ticks_reg),
        .drain_rate(drain_reg),
        .cost      (cost_reg),
        .capacity  (capacity_reg),
        .used      (credit),
        .send_ok   (send_ok)
    );

    // The sequencer. An item enters in IDLE, its first step runs in EXEC, build and
    // receive ops walk the slots one per step, and FINISH hands the result to the output
    // register as soon as that register is free.
    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        out_head_next    = out_head_reg;
        out_tail_next    = out_tail_reg;
        in_head_next     = in_head_reg;
        in_tail_next     = in_tail_reg;
        led_pending_next = led_pending_reg;
        led_dur_next     = led_dur_reg;
        last_data_next   = last_data_reg;
        in_ready         = 1'b0;
        work_clr         = 1'b0;
        acc_set          = 1'b0;
        acc_clr          = 1'b0;
        any_set          = 1'b0;
        slot_led         = 1'b0;
        slot_midi        = 1'b0;
        rx_load          = 1'b0;
        load_out         = 1'b0;
        out_we           = 1'b0;
        out_re           = 1'b0;
        in_we            = 1'b0;
        in_re            = 1'b0;
        cctl             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    work_clr   = 1'b1;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_FINISH;
                unique case (op_reg)
                    OP_QUEUE:
                    begin
                        if (!out_full)
                        begin
                            out_we        = 1'b1;
                            out_tail_next = out_tail_reg + 1'b1;
                            acc_set       = 1'b1;
                        end
                    end
                    OP_LED:
                    begin
                        led_pending_next = 1'b1;
                        led_dur_next     = data_reg;
                    end
                    OP_BUILD:
                    begin
                        slot_next  = '0;
                        state_next = ST_SLOT;
                    end
                    OP_RECV:
                    begin
                        cctl.load_product = 1'b1;
                        state_next        = ST_DRAIN;
                    end
                    OP_POP:
                    begin
                        if (in_count != '0)
                        begin
                            in_re        = 1'b1;
                            in_head_next = in_head_reg + 1'b1;
                            state_next   = ST_POP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_SLOT:
            begin
                if (led_pending_reg)
                begin
                    slot_led         = 1'b1;
                    led_pending_next = 1'b0;
                    led_dur_next     = '0;
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
                else if (!send_ok)
                begin
                    // No room left on the remote side: the rest of the frame stays empty.
                    state_next = ST_FINISH;
                end
                else if (out_count != '0)
                begin
                    out_re        = 1'b1;
                    out_head_next = out_head_reg + 1'b1;
                    state_next    = ST_SLOT_RD;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            ST_SLOT_RD:
            begin
                slot_midi   = 1'b1;
                cctl.charge = 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_SLOT;
                end
            end

            ST_DRAIN:
            begin
                cctl.drain = 1'b1;
                acc_set    = 1'b1;
                slot_next  = '0;
                state_next = ST_PUSH;
            end

            ST_PUSH:
            begin
                if (rtag_reg[slot_reg] != TAG_EMPTY)
                begin
                    any_set = 1'b1;
                    if (!in_full)
                    begin
                        in_we        = 1'b1;
                        in_tail_next = in_tail_reg + 1'b1;
                    end
                    else
                    begin
                        acc_clr = 1'b1;
                    end
                end
                if (slot_reg == LAST_SLOT)
                begin
                    last_data_next = any_reg || (rtag_reg[slot_reg] != TAG_EMPTY);
                    state_next     = ST_FINISH;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            ST_POP_RD:
            begin
                rx_load    = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            slot_reg        <= '0;
            out_head_reg    <= '0;
            out_tail_reg    <= '0;
            in_head_reg     <= '0;
            in_tail_reg     <= '0;
            led_pending_reg <= 1'b0;
            led_dur_reg     <= '0;
            last_data_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            capacity_reg    <= CAPACITY_RESET;
            cost_reg        <= COST_RESET;
            drain_reg       <= DRAIN_RESET;
            threshold_reg   <= NOTIFY_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            out_head_reg    <= out_head_next;
            out_tail_reg    <= out_tail_next;
            in_head_reg     <= in_head_next;
            in_tail_reg     <= in_tail_next;
            led_pending_reg <= led_pending_next;
            led_dur_reg     <= led_dur_next;
            last_data_reg   <= last_data_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CAPACITY: capacity_reg  <= cfg_data[CREDIT_W-1:0];
                    CFG_COST:     cost_reg      <= cfg_data[COST_W-1:0];
                    CFG_DRAIN:    drain_reg     <= cfg_data[CREDIT_W-1:0];
                    CFG_NOTIFY:   threshold_reg <= cfg_data[THR_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Payload registers: item capture, result assembly and the output beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg      <= op;
            data_reg    <= data_byte;
            rtag_reg[0] <= rx_tag0;
            rdat_reg[0] <= rx_data0;
            rtag_reg[1] <= rx_tag1;
            rdat_reg[1] <= rx_data1;
            ticks_reg   <= elapsed_ticks;
        end

        if (work_clr)
        begin
            acc_reg <= 1'b0;
        end
        else if (acc_set)
        begin
            acc_reg <= 1'b1;
        end
        else if (acc_clr)
        begin
            acc_reg <= 1'b0;
        end

        if (work_clr)
        begin
            any_reg <= 1'b0;
        end
        else if (any_set)
        begin
            any_reg <= 1'b1;
        end

        if (work_clr)
        begin
            for (int s = 0; s < MAX_IO_SLOTS; s++)
            begin
                tag_reg[s]  <= TAG_EMPTY;
                tdat_reg[s] <= '0;
            end
        end
        else if (slot_led)
        begin
            tag_reg[slot_reg]  <= TAG_LED;
            tdat_reg[slot_reg] <= led_dur_reg;
        end
        else if (slot_midi)
        begin
            tag_reg[slot_reg]  <= TAG_MIDI;
            tdat_reg[slot_reg] <= out_rdata;
        end

        if (work_clr)
        begin
            rxb_reg <= '0;
            rxv_reg <= 1'b0;
        end
        else if (rx_load)
        begin
            rxb_reg <= in_rdata;
            rxv_reg <= 1'b1;
        end

        // Status is sampled here, after every state update of the item has landed.
        if (load_out)
        begin
            o_acc_reg    <= acc_reg;
            o_tag_reg    <= tag_reg;
            o_tdat_reg   <= tdat_reg;
            o_rxb_reg    <= rxb_reg;
            o_rxv_reg    <= rxv_reg;
            o_notify_reg <= notify_now;
            o_more_reg   <= more_now;
            o_count_reg  <= in_count;
            o_credit_reg <= credit;
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign accepted    = o_acc_reg;
    assign tx_tag0     = o_tag_reg[0];
    assign tx_data0    = o_tdat_reg[0];
    assign tx_tag1     = o_tag_reg[1];
    assign tx_data1    = o_tdat_reg[1];
    assign rx_byte     = o_rxb_reg;
    assign rx_valid    = o_rxv_reg;
    assign notify      = o_notify_reg;
    assign more_work   = o_more_reg;
    assign input_count = o_count_reg;
    assign credit_used = o_credit_reg;

endmodule

// ----- hw/rtl/spi_midi_frame_bridge_chk.sv -----
// Port-level checker for the SPI MIDI frame bridge, bound to the top level.
// Depends on spi_mfb_pkg and spi_midi_frame_bridge_macros.svh.
`timescale 1ns / 1ps
`include "spi_midi_frame_bridge_macros.svh"

module spi_midi_frame_bridge_chk
    import spi_mfb_pkg::*;
#(
    parameter int CNT_W = 13
) (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                accepted,
    input logic [BYTE_W-1:0]   tx_tag0,
    input logic [BYTE_W-1:0]   tx_data0,
    input logic [BYTE_W-1:0]   tx_tag1,
    input logic [BYTE_W-1:0]   tx_data1,
    input logic [BYTE_W-1:0]   rx_byte,
    input logic                rx_valid,
    input logic                notify,
    input logic                more_work,
    input logic [CNT_W-1:0]    input_count,
    input logic [CREDIT_W-1:0] credit_used
);

    // A stalled result beat keeps its whole payload.
    `SMFB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable({accepted, tx_tag0, tx_data0, tx_tag1, tx_data1, rx_byte,
                              rx_valid, notify, more_work, input_count, credit_used}),
        "result beat changed while stalled")

    // An empty first slot means the frame was cut short, had nothing to send or was not built.
    `SMFB_ASSERT_NOW(a_empty_slot, clk, rst_n, out_valid && tx_tag0 == TAG_EMPTY,
        tx_data0 == 8'h00 && tx_tag1 == TAG_EMPTY && tx_data1 == 8'h00,
        "empty first slot followed by frame content")

    `SMFB_ASSERT_NOW(a_rx_zero, clk, rst_n, out_valid && !rx_valid, rx_byte == 8'h00,
        "popped byte nonzero without a pop")

    `SMFB_ASSERT_NOW(a_notify_count, clk, rst_n, out_valid && notify,
        input_count != '0, "notify raised on an empty input FIFO")

endmodule

bind spi_midi_frame_bridge spi_midi_frame_bridge_chk #(.CNT_W(CNT_W)) u_chk (.*);
